FILE: hw/rtl/smstep_pkg.sv
package smstep_pkg;

    // Default stack storage depth in words.
    localparam int SM_STACK_DEPTH = 1024;

    // Machine status codes.
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_HALT      = 3'd1;
    localparam logic [2:0] STS_ILL_INSTR = 3'd2;
    localparam logic [2:0] STS_ILL_OPND  = 3'd3;
    localparam logic [2:0] STS_BAD_ADDR  = 3'd4;
    localparam logic [2:0] STS_DIV_ZERO  = 3'd5;
    localparam logic [2:0] STS_IO        = 3'd6;
    localparam logic [2:0] STS_STACK     = 3'd7;

    // Opcodes.
    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_HALT  = 5'd1;
    localparam logic [4:0] OP_ADD   = 5'd2;
    localparam logic [4:0] OP_SUB   = 5'd3;
    localparam logic [4:0] OP_MUL   = 5'd4;
    localparam logic [4:0] OP_DIV   = 5'd5;
    localparam logic [4:0] OP_INC   = 5'd6;
    localparam logic [4:0] OP_DEC   = 5'd7;
    localparam logic [4:0] OP_LOOP  = 5'd8;
    localparam logic [4:0] OP_MOVR  = 5'd9;
    localparam logic [4:0] OP_LOAD  = 5'd10;
    localparam logic [4:0] OP_STORE = 5'd11;
    localparam logic [4:0] OP_IN    = 5'd12;
    localparam logic [4:0] OP_GET   = 5'd13;
    localparam logic [4:0] OP_OUT   = 5'd14;
    localparam logic [4:0] OP_PUT   = 5'd15;
    localparam logic [4:0] OP_SWAP  = 5'd16;
    localparam logic [4:0] OP_PUSH  = 5'd17;
    localparam logic [4:0] OP_POP   = 5'd18;
    localparam logic [31:0] OP_LAST = 32'd18;

    // Console input kinds.
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_EOF   = 2'd1;

    // Largest code accepted by PUT.
    localparam logic [31:0] CHAR_MAX = 32'd255;

    // Configuration register indexes.
    localparam logic CFG_CODE_LIMIT = 1'b0;
    localparam logic CFG_STACK_CAP  = 1'b1;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } smstep_alu_op_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic           start;
        smstep_alu_op_t op;
    } smstep_alu_req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_ALU,
        SQ_MEM,
        SQ_DONE
    } smstep_state_t;

    // Number of argument words that follow each opcode.
    function automatic logic [1:0] arg_count(input logic [4:0] op);
        logic [1:0] n;
        case (op)
            OP_NOP, OP_HALT: n = 2'd0;
            OP_MOVR, OP_LOAD, OP_STORE, OP_SWAP: n = 2'd2;
            default: n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

FILE: hw/rtl/smstep_ram.sv
module smstep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port with registered read; a read in the cycle of a write returns the old word.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: hw/rtl/smstep_alu.sv
module smstep_alu (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  smstep_pkg::smstep_alu_req_t req,
    input  logic [31:0]                opa,
    input  logic [31:0]                opb,
    output logic                       done,
    output logic [31:0]                result
);
    import smstep_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] mb_reg, mb_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] trial;
    logic [31:0] quo_step;
    logic [31:0] ma;
    logic [31:0] mbv;
    logic [63:0] prod;

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    // One restoring division step per cycle, or a registered add, subtract or multiply.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        ma   = opa[31] ? (32'd0 - opa) : opa;
        mbv  = opb[31] ? (32'd0 - opb) : opb;
        prod = opa * opb;
        trial = {rem_reg, quo_reg[31]} - {1'b0, mb_reg};
        quo_step = {quo_reg[30:0], ~trial[32]};

        if (busy_reg) begin
            quo_next = quo_step;
            rem_next = trial[32] ? {rem_reg[30:0], quo_reg[31]} : trial[31:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (32'd0 - quo_step) : quo_step;
            end
        end else if (req.start) begin
            case (req.op)
                ALU_ADD: begin
                    res_next  = opa + opb;
                    done_next = 1'b1;
                end
                ALU_SUB: begin
                    res_next  = opa - opb;
                    done_next = 1'b1;
                end
                ALU_MUL: begin
                    res_next  = prod[31:0];
                    done_next = 1'b1;
                end
                default: begin
                    busy_next = 1'b1;
                    cnt_next  = '0;
                    rem_next  = '0;
                    quo_next  = ma;
                    mb_next   = mbv;
                    neg_next  = opa[31] ^ opb[31];
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/stack_machine_step.sv
// Channel   Direction  Ports                       Contents
// s_        in         s_tvalid/s_tready/s_tdata   one instruction with console input
//                      s_tuser                      console input kind
// m_        out        m_tvalid/m_tready/m_tdata   machine state after the step
//                      m_tuser                      output is a character
// apb       in         psel/penable/pwrite/paddr   code_limit at 0, stack_capacity at 4
//
// An instruction passes through accept, execute and load of the output word; add, sub,
// mul, inc, dec and div also wait in the shared arithmetic unit, division for all of its
// restoring steps, and load and pop add a state for the registered stack memory read.
// s_tready is high only while the sequencer is idle, so the next instruction is taken
// while a finished word still waits in the output register; that instruction then holds
// in its last state until the m_ side takes the waiting word.
// Reset is synchronous and clears registers, pc, depth and status; the stack memory is
// not cleared, and reads only ever reach entries that push or store have written.
module stack_machine_step #(
    parameter int STACK_DEPTH = smstep_pkg::SM_STACK_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode_word, arg_first, arg_second, in_value
    input  logic [127:0] s_tdata,
    // in_kind
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status_out, step_ok, next_pc, stack_used, reg_a, reg_b, reg_c, reg_d,
    // out_valid, out_value, input_taken, zero padding
    output logic [215:0] m_tdata,
    // out_is_char
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import smstep_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (DW > 11) ? DW : 11;

    smstep_state_t state_reg, state_next;

    logic [30:0]       code_limit_reg;
    logic [10:0]       cap_reg;
    logic [3:0][31:0]  gp_reg, gp_next;
    logic [31:0]       pc_reg, pc_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [2:0]        status_reg, status_next;
    logic [31:0]       op_reg, a1_reg, a2_reg, ival_reg;
    logic [1:0]        kind_reg;
    logic              ok_reg, ok_next;
    logic              ov_reg, ov_next;
    logic              oc_reg, oc_next;
    logic [31:0]       oval_reg, oval_next;
    logic              taken_reg, taken_next;
    logic              m_valid_reg, m_valid_next;
    logic [215:0]      m_data_reg, m_data_next;
    logic              m_char_reg, m_char_next;

    logic [4:0]        op5;
    logic [1:0]        r_idx;
    logic [1:0]        r2_idx;
    logic [1:0]        argc;
    logic [31:0]       pc_adv;
    logic [32:0]       pc_end;
    logic              pc_bad, op_bad, arg_bad, r_bad, r2_bad;
    logic [31:0]       reg_r;
    logic [32:0]       off;
    logic [32:0]       slot_raw;
    logic              slot_ok;
    logic [CW-1:0]     cap_eff;
    logic              push_ok;
    logic              cfg_wr;

    smstep_alu_req_t   alu_req;
    logic [31:0]       alu_a, alu_b, alu_res;
    logic              alu_done;
    logic              is_incdec;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [31:0]       ram_rdata;

    smstep_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    smstep_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (reg_r),
        .rdata (ram_rdata)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == CFG_STACK_CAP) ? {21'd0, cap_reg} : {1'b0, code_limit_reg};

    assign s_tready = (state_reg == SQ_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_char_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SQ_IDLE;
            code_limit_reg <= '0;
            cap_reg        <= 11'd1024;
            gp_reg         <= '0;
            pc_reg         <= '0;
            depth_reg      <= '0;
            status_reg     <= STS_OK;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gp_reg      <= gp_next;
            pc_reg      <= pc_next;
            depth_reg   <= depth_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr) begin
                if (paddr[2] == CFG_STACK_CAP) begin
                    cap_reg <= pwdata[10:0];
                end else begin
                    code_limit_reg <= pwdata[30:0];
                end
            end
        end
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tdata[31:0];
            a1_reg   <= s_tdata[63:32];
            a2_reg   <= s_tdata[95:64];
            ival_reg <= s_tdata[127:96];
            kind_reg <= s_tuser;
        end
        ok_reg     <= ok_next;
        ov_reg     <= ov_next;
        oc_reg     <= oc_next;
        oval_reg   <= oval_next;
        taken_reg  <= taken_next;
        m_data_reg <= m_data_next;
        m_char_reg <= m_char_next;
    end

    // Decode and operand checks on the held instruction.
    always_comb begin
        op5     = op_reg[4:0];
        r_idx   = a1_reg[1:0];
        r2_idx  = a2_reg[1:0];
        argc    = arg_count(op5);
        pc_adv  = pc_reg + 32'd1 + 32'(argc);
        pc_end  = {1'b0, pc_reg} + 33'(argc);
        pc_bad  = pc_reg[31] || (pc_reg > {1'b0, code_limit_reg});
        op_bad  = op_reg > OP_LAST;
        arg_bad = pc_end > {2'b00, code_limit_reg};
        r_bad   = a1_reg[31:2] != 30'd0;
        r2_bad  = a2_reg[31:2] != 30'd0;
        reg_r   = gp_reg[r_idx];
        off     = {gp_reg[3][31], gp_reg[3]} + {a2_reg[31], a2_reg};
        slot_ok = !off[32] && (off < 33'(depth_reg));
        slot_raw = 33'(depth_reg) - 33'd1 - off;
        cap_eff = (CW'(cap_reg) > CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH) : CW'(cap_reg);
        push_ok = CW'(depth_reg) < cap_eff;
        is_incdec = (op5 == OP_INC) || (op5 == OP_DEC);
        alu_a   = is_incdec ? reg_r : gp_reg[0];
        alu_b   = is_incdec ? 32'd1 : reg_r;
    end

    // Sequencer: next state, register file updates and output word.
    always_comb begin
        state_next   = state_reg;
        gp_next      = gp_reg;
        pc_next      = pc_reg;
        depth_next   = depth_reg;
        status_next  = status_reg;
        ok_next      = ok_reg;
        ov_next      = ov_reg;
        oc_next      = oc_reg;
        oval_next    = oval_reg;
        taken_next   = taken_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_char_next  = m_char_reg;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        ram_we   = 1'b0;
        ram_addr = slot_raw[AW-1:0];

        case (state_reg)
            SQ_IDLE: begin
                if (s_tvalid) begin
                    state_next = SQ_EXEC;
                    ok_next    = 1'b0;
                    ov_next    = 1'b0;
                    oc_next    = 1'b0;
                    oval_next  = '0;
                    taken_next = 1'b0;
                end
            end

            SQ_EXEC: begin
                state_next = SQ_DONE;
                if (status_reg != STS_OK) begin
                    status_next = status_reg;
                end else if (pc_bad) begin
                    status_next = STS_BAD_ADDR;
                end else if (op_bad) begin
                    status_next = STS_ILL_INSTR;
                end else if (arg_bad) begin
                    status_next = STS_BAD_ADDR;
                end else if (op5 == OP_NOP) begin
                    ok_next = 1'b1;
                    pc_next = pc_adv;
                end else if (op5 == OP_HALT) begin
                    status_next = STS_HALT;
                    pc_next     = pc_reg + 32'd1;
                end else if (op5 == OP_LOOP) begin
                    ok_next = 1'b1;
                    pc_next = (gp_reg[2] != 32'd0) ? a1_reg : (pc_reg + 32'd2);
                end else if (r_bad) begin
                    status_next = STS_ILL_OPND;
                end else begin
                    case (op5)
                        OP_ADD, OP_INC: begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_ADD;
                            state_next    = SQ_ALU;
                        end
                        OP_SUB, OP_DEC: begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_SUB;
                            state_next    = SQ_ALU;
                        end
                        OP_MUL: begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_MUL;
                            state_next    = SQ_ALU;
                        end
                        OP_DIV: begin
                            if (reg_r == 32'd0) begin
                                status_next = STS_DIV_ZERO;
                            end else begin
                                alu_req.start = 1'b1;
                                alu_req.op    = ALU_DIV;
                                state_next    = SQ_ALU;
                            end
                        end
                        OP_MOVR: begin
                            gp_next[r_idx] = a2_reg;
                            ok_next        = 1'b1;
                            pc_next        = pc_adv;
                        end
                        OP_LOAD: begin
                            if (slot_ok) begin
                                state_next = SQ_MEM;
                            end else begin
                                status_next = STS_STACK;
                            end
                        end
                        OP_STORE: begin
                            if (slot_ok) begin
                                ram_we  = 1'b1;
                                ok_next = 1'b1;
                                pc_next = pc_adv;
                            end else begin
                                status_next = STS_STACK;
                            end
                        end
                        OP_IN, OP_GET: begin
                            if (kind_reg == KIND_VALUE) begin
                                gp_next[r_idx] = ival_reg;
                                taken_next     = 1'b1;
                                ok_next        = 1'b1;
                                pc_next        = pc_adv;
                            end else if (kind_reg == KIND_EOF || op5 == OP_GET) begin
                                // End of input clears C first, then the target takes -1.
                                gp_next[2]     = '0;
                                gp_next[r_idx] = '1;
                                taken_next     = 1'b1;
                                ok_next        = 1'b1;
                                pc_next        = pc_adv;
                            end else begin
                                status_next = STS_IO;
                            end
                        end
                        OP_OUT: begin
                            ov_next   = 1'b1;
                            oval_next = reg_r;
                            ok_next   = 1'b1;
                            pc_next   = pc_adv;
                        end
                        OP_PUT: begin
                            if (reg_r <= CHAR_MAX) begin
                                ov_next   = 1'b1;
                                oc_next   = 1'b1;
                                oval_next = reg_r;
                                ok_next   = 1'b1;
                                pc_next   = pc_adv;
                            end else begin
                                status_next = STS_ILL_OPND;
                            end
                        end
                        OP_SWAP: begin
                            if (r2_bad) begin
                                status_next = STS_ILL_OPND;
                            end else begin
                                gp_next[r_idx]  = gp_reg[r2_idx];
                                gp_next[r2_idx] = reg_r;
                                ok_next         = 1'b1;
                                pc_next         = pc_adv;
                            end
                        end
                        OP_PUSH: begin
                            if (push_ok) begin
                                ram_addr   = depth_reg[AW-1:0];
                                ram_we     = 1'b1;
                                depth_next = depth_reg + DW'(1);
                                ok_next    = 1'b1;
                                pc_next    = pc_adv;
                            end else begin
                                status_next = STS_STACK;
                            end
                        end
                        OP_POP: begin
                            if (depth_reg != '0) begin
                                ram_addr   = AW'(depth_reg - DW'(1));
                                state_next = SQ_MEM;
                            end else begin
                                status_next = STS_STACK;
                            end
                        end
                        default: begin
                            status_next = status_reg;
                        end
                    endcase
                end
            end

            // Wait for the arithmetic unit; A takes the result, or the operand for inc/dec.
            SQ_ALU: begin
                if (alu_done) begin
                    if (is_incdec) begin
                        gp_next[r_idx] = alu_res;
                    end else begin
                        gp_next[0] = alu_res;
                    end
                    ok_next    = 1'b1;
                    pc_next    = pc_adv;
                    state_next = SQ_DONE;
                end
            end

            // Stack read data for the address presented in execute arrives in the cycle after.
            SQ_MEM: begin
                gp_next[r_idx] = ram_rdata;
                if (op5 == OP_POP) begin
                    depth_next = depth_reg - DW'(1);
                end
                ok_next    = 1'b1;
                pc_next    = pc_adv;
                state_next = SQ_DONE;
            end

            SQ_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_char_next  = oc_reg;
                    m_data_next  = {7'd0, taken_reg, oval_reg, ov_reg,
                                    gp_reg[3], gp_reg[2], gp_reg[1], gp_reg[0],
                                    11'(depth_reg), pc_reg, ok_reg, status_reg};
                    state_next   = SQ_IDLE;
                end
            end

            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

endmodule
